[src/crc8_word_frame_deframer_defines.svh]
// assertion macros for the crc8 word deframer
`ifndef CRC8_WORD_FRAME_DEFRAMER_DEFINES_SVH
`define CRC8_WORD_FRAME_DEFRAMER_DEFINES_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define CRC8WD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crc8wd check failed");

// condition that must never be seen
`define CRC8WD_ASSERT_NEVER(name, clk, rst_n, cond) \
  `CRC8WD_ASSERT(name, clk, rst_n, !(cond))

`endif

[src/crc8wd_pkg.sv]
package crc8wd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [1:0] WpvOneWord = 2'd1;
  localparam logic [1:0] WpvReset   = 2'd2;
  localparam logic [4:0] VpfReset   = 5'd10;

  localparam logic CfgIdxWpv = 1'b0;
  localparam logic CfgIdxVpf = 1'b1;

  typedef struct packed {
    logic       one_word;
    logic [4:0] vpf;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        crc_ok;
    logic [3:0]  value_index;
    logic        frame_error;
    logic        last;
  } res_t;

  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/crc8wd_byte_if.sv]
interface crc8wd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

[src/crc8wd_value_if.sv]
interface crc8wd_value_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        crc_ok;
  logic [3:0]  value_index;
  logic        frame_error;
  logic        last;

  modport source (
    output valid, output value_bits, output crc_ok, output value_index,
    output frame_error, output last, input ready
  );
  modport sink (
    input valid, input value_bits, input crc_ok, input value_index,
    input frame_error, input last, output ready
  );
endinterface

[src/crc8wd_cfg.sv]
module crc8wd_cfg #(
  parameter int MAX_VALUES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [4:0]         cfg_wdata_i,
  output crc8wd_pkg::cfg_t   cfg_o
);
  import crc8wd_pkg::*;

  localparam logic [6:0] MaxV = 7'(MAX_VALUES);

  logic [1:0] wpv_q;
  logic [4:0] vpf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpv_q <= WpvReset;
      vpf_q <= VpfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxWpv: wpv_q <= cfg_wdata_i[1:0];
        CfgIdxVpf: vpf_q <= cfg_wdata_i;
        default:   wpv_q <= wpv_q;
      endcase
    end
  end

  always_comb begin
    cfg_o.one_word = (wpv_q == WpvOneWord);
    priority if (vpf_q == 5'd0) begin
      cfg_o.vpf = 5'd1;
    end else if ({2'b00, vpf_q} > MaxV) begin
      cfg_o.vpf = MaxV[4:0];
    end else begin
      cfg_o.vpf = vpf_q;
    end
  end

endmodule

[src/crc8wd_core.sv]
`include "crc8_word_frame_deframer_defines.svh"

module crc8wd_core #(
  parameter int MAX_VALUES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               restart_i,
  input  crc8wd_pkg::cfg_t   cfg_i,
  output logic               res_valid_o,
  output crc8wd_pkg::res_t   res_o
);
  import crc8wd_pkg::*;

  localparam int CntW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int IdxW = CntW + 4;

  localparam logic [1:0] PhHi  = 2'd0;
  localparam logic [1:0] PhLo  = 2'd1;
  localparam logic [1:0] PhCrc = 2'd2;

  logic [1:0]      phase_q, phase_d, phase_e;
  logic [7:0]      crc_q, crc_d, crc_e;
  logic [15:0]     hold_q, hold_d;
  logic [15:0]     upper_q, upper_d;
  logic            wp_q, wp_d, wp_e;
  logic            ok_q, ok_d, ok_e;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_e;
  logic            err_q, err_d, err_e;

  logic            match, ok_now, err_now, is_last;
  logic [6:0]      cnt_next;
  logic [IdxW-1:0] idx_ext;

  always_comb begin
    phase_e = restart_i ? PhHi    : phase_q;
    crc_e   = restart_i ? CrcInit : crc_q;
    wp_e    = restart_i ? 1'b0    : wp_q;
    ok_e    = restart_i ? 1'b1    : ok_q;
    cnt_e   = restart_i ? '0      : cnt_q;
    err_e   = restart_i ? 1'b0    : err_q;

    match    = (rx_byte_i == crc_e);
    ok_now   = ok_e & match;
    err_now  = err_e | ~match;
    cnt_next = 7'(cnt_e) + 7'd1;
    is_last  = (cnt_next >= {2'b00, cfg_i.vpf});
    idx_ext  = IdxW'(cnt_e);

    phase_d = phase_e;
    crc_d   = crc_e;
    hold_d  = hold_q;
    upper_d = upper_q;
    wp_d    = wp_e;
    ok_d    = ok_e;
    cnt_d   = cnt_e;
    err_d   = err_e;

    res_valid_o       = 1'b0;
    res_o.value_bits  = cfg_i.one_word ? {16'h0000, hold_q} : {upper_q, hold_q};
    res_o.crc_ok      = ok_now;
    res_o.value_index = idx_ext[3:0];
    res_o.frame_error = err_now;
    res_o.last        = is_last;

    unique case (phase_e)
      PhHi: begin
        crc_d   = crc8_feed(CrcInit, rx_byte_i);
        hold_d  = {rx_byte_i, 8'h00};
        phase_d = PhLo;
      end
      PhLo: begin
        crc_d   = crc8_feed(crc_e, rx_byte_i);
        hold_d  = {hold_q[15:8], rx_byte_i};
        phase_d = PhCrc;
      end
      default: begin
        phase_d = PhHi;
        crc_d   = CrcInit;
        err_d   = err_now;
        if (!cfg_i.one_word && !wp_e) begin
          upper_d = hold_q;
          wp_d    = 1'b1;
          ok_d    = ok_now;
        end else begin
          res_valid_o = 1'b1;
          wp_d        = 1'b0;
          ok_d        = 1'b1;
          if (is_last) begin
            cnt_d = '0;
            err_d = 1'b0;
          end else begin
            cnt_d = cnt_e + CntW'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHi;
      crc_q   <= CrcInit;
      wp_q    <= 1'b0;
      ok_q    <= 1'b1;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else if (proc_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      wp_q    <= wp_d;
      ok_q    <= ok_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_i) begin
      hold_q  <= hold_d;
      upper_q <= upper_d;
    end
  end

  `CRC8WD_ASSERT_NEVER(a_phase_legal, clk_i, rst_ni, phase_q == 2'd3)
  `CRC8WD_ASSERT(a_cnt_bound, clk_i, rst_ni, 7'(cnt_q) < 7'(MAX_VALUES))
  `CRC8WD_ASSERT(a_last_wraps, clk_i, rst_ni, proc_i && res_valid_o && res_o.last |=> cnt_q == '0)

endmodule

[src/crc8_word_frame_deframer.sv]
// crc8 word deframer for a sensor response stream
// rx_i carries one received byte per beat with a restart flag that marks the
// first byte of a new frame; bytes come in groups of high data, low data and
// crc-8 (poly 0x31, init 0xff). val_o gives one beat per completed value of
// one or two words with crc_ok, value_index, sticky frame_error and last.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write words_per_value (0) and
// values_per_frame (1); write only while no byte is in flight.
// a value is worked on from the input register, which holds the beat that
// carries its final crc byte, straight into the result register behind val_o
// throughput: one byte per cycle while val_o is not stalled; the per-byte crc
// update is one 8-step shift chain from the input register to the crc register
// reset: frame state cleared, words_per_value 2, values_per_frame 10, both
// channels empty. a stalled val_o holds its beat; the input register keeps
// taking bytes until it is full too, then rx_i.ready drops.
`include "crc8_word_frame_deframer_defines.svh"

module crc8_word_frame_deframer #(
  parameter int MAX_VALUES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8wd_byte_if.sink   rx_i,
  crc8wd_value_if.source val_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [4:0]    cfg_wdata_i
);
  import crc8wd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       advance;
  logic       proc;
  logic       res_valid;
  res_t       res;
  cfg_t       cfg;

  assign advance    = !out_valid_q || val_o.ready;
  assign proc       = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q    <= rx_i.rx_byte;
      in_restart_q <= rx_i.restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= proc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      out_res_q <= res;
    end
  end

  crc8wd_cfg #(
    .MAX_VALUES(MAX_VALUES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  crc8wd_core #(
    .MAX_VALUES(MAX_VALUES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .proc_i     (proc),
    .rx_byte_i  (in_byte_q),
    .restart_i  (in_restart_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign val_o.valid       = out_valid_q;
  assign val_o.value_bits  = out_res_q.value_bits;
  assign val_o.crc_ok      = out_res_q.crc_ok;
  assign val_o.value_index = out_res_q.value_index;
  assign val_o.frame_error = out_res_q.frame_error;
  assign val_o.last        = out_res_q.last;

  `CRC8WD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !rx_i.ready |-> in_valid_q)
  `CRC8WD_ASSERT(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q) |-> $past(in_valid_q))
  `CRC8WD_ASSERT(a_stage_holds, clk_i, rst_ni, in_valid_q && !advance |=> in_valid_q)

endmodule

[sim/crc8_word_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module crc8_word_frame_deframer_tb;
  import crc8wd_pkg::*;

  localparam int MaxValues     = 16;
  localparam int NumPhases     = 12;
  localparam int PhaseBytes    = 125;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam int DirRows       = 22;

  typedef struct packed {
    logic [7:0] b;
    logic       rs;
    logic       typed;
    res_t       res;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [4:0] cfg_wdata_i;

  crc8wd_byte_if  rx_if ();
  crc8wd_value_if val_if ();

  crc8_word_frame_deframer #(
    .MAX_VALUES(MaxValues)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_if),
    .val_o      (val_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [1:0]  cfg_wpv;
  logic [4:0]  cfg_vpf;
  logic [1:0]  grp_pos;
  logic [7:0]  crc_acc;
  logic [15:0] data_word;
  logic [15:0] hi_word;
  logic        in_second_word;
  logic        words_good;
  logic [3:0]  vals_done;
  logic        err_sticky;

  res_t pending_values[$];
  res_t want_val;
  int   errors = 0;
  int   quiet_cycles = 0;
  int   sent = 0;
  bit   idle_on = 1'b1;
  bit   src_gap_en = 1'b1;
  bit   hold_req = 1'b0;

  dir_row_t dir_tbl [DirRows] = '{
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b1, {32'hBEEF0000, 1'b1, 4'd0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, {32'hFFFFFFFF, 1'b0, 4'd1, 1'b1, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b1, {32'hFFFFBEEF, 1'b1, 4'd0, 1'b0, 1'b0}},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b1, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0},
    '{8'h77, 1'b0, 1'b0, '0}
  };

  int wpv_plan [NumPhases] = '{1, 2, 0, 3, 1, 2, 1, 0, 1, 3, 2, 1};
  int vpf_plan [NumPhases] = '{1, 16, 0, 31, 2, 17, 5, 16, 1, 10, 3, 7};

  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] s;
    logic       fb;
    s = c;
    for (int i = 7; i >= 0; i--) begin
      fb = s[7] ^ d[i];
      s  = {s[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return s;
  endfunction

  function automatic int vpf_eff();
    if (cfg_vpf == 5'd0) return 1;
    if (cfg_vpf > MaxValues) return MaxValues;
    return int'(cfg_vpf);
  endfunction

  task automatic frame_reset();
    grp_pos        = 2'd0;
    crc_acc        = CrcInit;
    data_word      = 16'h0000;
    hi_word        = 16'h0000;
    in_second_word = 1'b0;
    words_good     = 1'b1;
    vals_done      = 4'd0;
    err_sticky     = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic rs, output logic got,
                              output res_t r);
    logic [31:0] v;
    logic        fin;
    got = 1'b0;
    r   = '0;
    if (rs) frame_reset();
    case (grp_pos)
      2'd0: begin
        crc_acc   = crc8_next(CrcInit, b);
        data_word = {b, 8'h00};
        grp_pos   = 2'd1;
      end
      2'd1: begin
        crc_acc        = crc8_next(crc_acc, b);
        data_word[7:0] = b;
        grp_pos        = 2'd2;
      end
      default: begin
        grp_pos = 2'd0;
        if (b != crc_acc) begin
          err_sticky = 1'b1;
          words_good = 1'b0;
        end
        crc_acc = CrcInit;
        if (cfg_wpv != WpvOneWord && !in_second_word) begin
          hi_word        = data_word;
          in_second_word = 1'b1;
        end else begin
          v   = (cfg_wpv == WpvOneWord) ? {16'h0000, data_word} : {hi_word, data_word};
          fin = (int'(vals_done) + 1 >= vpf_eff());
          r   = '{value_bits: v, crc_ok: words_good, value_index: vals_done,
                  frame_error: err_sticky, last: fin};
          got = 1'b1;
          in_second_word = 1'b0;
          words_good     = 1'b1;
          if (fin) begin
            vals_done  = 4'd0;
            err_sticky = 1'b0;
          end else begin
            vals_done = vals_done + 4'd1;
          end
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_byte(input logic [7:0] b, input logic rs, input logic use_typed,
                           input res_t typed_res);
    logic got;
    res_t r;
    if (src_gap_en && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.restart <= rs;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    deframe_byte(b, rs, got, r);
    if (use_typed) pending_values.push_back(typed_res);
    else if (got) pending_values.push_back(r);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_group(input logic rs, input logic bad, input logic rs_mid);
    logic [15:0] w;
    logic [7:0]  c;
    case ($urandom_range(0, 15))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      default: w = 16'($urandom);
    endcase
    c = crc8_next(crc8_next(CrcInit, w[15:8]), w[7:0]);
    if (bad) c = c ^ 8'($urandom_range(1, 255));
    push_byte(w[15:8], rs, 1'b0, '0);
    push_byte(w[7:0], rs_mid, 1'b0, '0);
    push_byte(c, 1'b0, 1'b0, '0);
  endtask

  task automatic send_frame();
    int n_groups;
    n_groups = vpf_eff() * ((cfg_wpv == WpvOneWord) ? 1 : 2);
    if ($urandom_range(0, 7) == 0) n_groups = $urandom_range(1, n_groups + 3);
    src_gap_en = idle_on && ($urandom_range(0, 3) != 0);
    for (int g = 0; g < n_groups; g++) begin
      if ($urandom_range(0, 39) == 0) push_byte(8'($urandom), 1'($urandom), 1'b0, '0);
      send_group(g == 0 && $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0,
                 $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] wpv, input logic [4:0] vpf);
    logic [4:0] d;
    d = {3'($urandom_range(0, 7)), wpv};
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgIdxWpv;
    cfg_wdata_i <= d;
    cfg_wpv = d[1:0];
    @(negedge clk_i);
    cfg_idx_i   <= CfgIdxVpf;
    cfg_wdata_i <= vpf;
    cfg_vpf = vpf;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    val_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        val_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        val_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        val_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        val_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        val_if.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end else begin
        val_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && val_if.valid && val_if.ready) begin
      if (pending_values.size() == 0) begin
        $error("unexpected value beat, value_bits %h", val_if.value_bits);
        errors++;
      end else begin
        want_val = pending_values.pop_front();
        if (val_if.value_bits !== want_val.value_bits) begin
          $error("value_bits: expected %h, got %h", want_val.value_bits, val_if.value_bits);
          errors++;
        end
        if (val_if.crc_ok !== want_val.crc_ok) begin
          $error("crc_ok: expected %b, got %b", want_val.crc_ok, val_if.crc_ok);
          errors++;
        end
        if (val_if.value_index !== want_val.value_index) begin
          $error("value_index: expected %0d, got %0d", want_val.value_index,
                 val_if.value_index);
          errors++;
        end
        if (val_if.frame_error !== want_val.frame_error) begin
          $error("frame_error: expected %b, got %b", want_val.frame_error,
                 val_if.frame_error);
          errors++;
        end
        if (val_if.last !== want_val.last) begin
          $error("last: expected %b, got %b", want_val.last, val_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (val_if.valid && val_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("crc8_word_frame_deframer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    rx_if.restart = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgIdxWpv;
    cfg_wdata_i   = 5'd0;
    cfg_wpv       = WpvReset;
    cfg_vpf       = VpfReset;
    frame_reset();
    vpf_plan[10] = $urandom_range(0, 31);
    vpf_plan[11] = $urandom_range(1, 16);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DirRows; k++) begin
      push_byte(dir_tbl[k].b, dir_tbl[k].rs, dir_tbl[k].typed, dir_tbl[k].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p == NumPhases - 1) idle_on = 1'b0;
      set_config(2'(wpv_plan[p]), 5'(vpf_plan[p]));
      if (p == 3) hold_req = 1'b1;
      for (int target = sent + PhaseBytes; sent < target; ) send_frame();
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending_values.size() == 0) begin
      $display("crc8_word_frame_deframer test passed");
    end else begin
      $display("crc8_word_frame_deframer test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/crc8wd_pkg.sv
src/crc8wd_byte_if.sv
src/crc8wd_value_if.sv
src/crc8wd_cfg.sv
src/crc8wd_core.sv
src/crc8_word_frame_deframer.sv
sim/crc8_word_frame_deframer_tb.sv
